// ----- hw/rtl/sdta_pkg.sv -----
// shared types, constants and the shift-add-3 step for the decimal converter
package sdta_pkg;

  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned NUM_DIGITS     = 10;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int unsigned IDX_W          = $clog2(NUM_DIGITS);
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // one number in flight through the conversion pipeline
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } sdta_work_t;

  // one double-dabble step: adjust every digit, then shift one binary bit in
  function automatic sdta_work_t dabble_step(sdta_work_t w);
    sdta_work_t       r;
    logic [DIGIT_W-1:0] d;
    r = w;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = r.bcd[i*DIGIT_W +: DIGIT_W];
      if (d >= 4'd5) begin
        r.bcd[i*DIGIT_W +: DIGIT_W] = d + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

endpackage

// ----- hw/rtl/sdta_dabble_stage.sv -----
// one register stage of the binary to bcd pipeline, BITS_PER_STAGE dabble steps deep
module sdta_dabble_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  sdta_pkg::sdta_work_t s_data_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output sdta_pkg::sdta_work_t m_data_o
);
  import sdta_pkg::*;

  logic       valid_q;
  sdta_work_t data_q, data_d;

  // stage advances when empty or when downstream takes the held request
  assign s_ready_o = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

  // chained dabble steps for this stage
  always_comb begin
    data_d = s_data_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- hw/rtl/sdta_serializer.sv -----
// emits sign and significant digits of one bcd number, one character per cycle while the output is ready
module sdta_serializer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  sdta_pkg::sdta_work_t         s_data_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [sdta_pkg::CHAR_W-1:0]  m_char_o,
  output logic                         m_last_o
);
  import sdta_pkg::*;

  logic             busy_q;
  logic             neg_q;
  logic [IDX_W-1:0] idx_q;
  logic [BCD_W-1:0] bcd_q;
  logic [IDX_W-1:0] top_idx;
  logic [DIGIT_W-1:0] digit;
  logic             take;
  logic             load;

  // highest nonzero digit sets the text length, zero gives one digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (s_data_i.bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  // current character from the held number
  assign digit     = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
  assign m_valid_o = busy_q;
  assign m_char_o  = neg_q ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(digit));
  assign m_last_o  = !neg_q && (idx_q == '0);

  assign take      = busy_q && m_ready_i;
  assign s_ready_o = !busy_q || (m_ready_i && m_last_o);
  assign load      = s_valid_i && s_ready_o;

  // character walk: sign first, then digits downward
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      neg_q  <= s_data_i.neg;
      idx_q  <= top_idx;
    end else if (take) begin
      if (m_last_o) begin
        busy_q <= 1'b0;
      end else if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= s_data_i.bcd;
    end
  end

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_top.sv -----
// Signed 32-bit integer to decimal ASCII text, one character per output request.
// The input passes through the sign stage, eight double-dabble stages and the
// character serializer before its first character is valid.
// Each number prints as 1 to 11 characters, and the single-character output port
// sets the pace; the pipeline buffers numbers behind it.
// Reset clears all valid bits and the serializer; payload registers are not reset.
module signed_int_to_decimal_ascii_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic signed [sdta_pkg::VALUE_W-1:0] s_axis_tdata_i,  // [31:0] value
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sdta_pkg::CHAR_W-1:0]        m_axis_tdata_o,  // [7:0] character
  output logic                               m_axis_tlast_o   // last_char
);
  import sdta_pkg::*;

  logic       valid [NUM_STAGES+1];
  logic       ready [NUM_STAGES+2];
  sdta_work_t work  [NUM_STAGES+1];

  logic       sign_valid_q;
  sdta_work_t sign_q, sign_d;

  // sign stage: split into sign and unsigned magnitude
  always_comb begin
    sign_d.neg = s_axis_tdata_i[VALUE_W-1];
    sign_d.bin = sign_d.neg ? (VALUE_W'(0) - VALUE_W'(s_axis_tdata_i))
                            : VALUE_W'(s_axis_tdata_i);
    sign_d.bcd = '0;
  end

  assign ready[0]        = !sign_valid_q || ready[1];
  assign s_axis_tready_o = ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_valid_q <= 1'b0;
    end else if (ready[0]) begin
      sign_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0] && s_axis_tvalid_i) begin
      sign_q <= sign_d;
    end
  end

  assign valid[0] = sign_valid_q;
  assign work[0]  = sign_q;

  // binary to bcd pipeline
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    sdta_dabble_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .s_valid_i (valid[g]),
      .s_ready_o (ready[g+1]),
      .s_data_i  (work[g]),
      .m_valid_o (valid[g+1]),
      .m_ready_i (ready[g+2]),
      .m_data_o  (work[g+1])
    );
  end

  // character output
  sdta_serializer u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (valid[NUM_STAGES]),
    .s_ready_o (ready[NUM_STAGES+1]),
    .s_data_i  (work[NUM_STAGES]),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_char_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule
